// ===== design/pett_pkg.sv =====
// Shared types and codes for the polled event trigger table.
`timescale 1ns / 1ps

package pett_pkg;

    // Operation codes carried by an input word.
    localparam logic [2:0] OP_POLL    = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_DELETE  = 3'd2;
    localparam logic [2:0] OP_ENABLE  = 3'd3;
    localparam logic [2:0] OP_DISABLE = 3'd4;

    // Trigger kinds held in a slot.
    localparam logic [3:0] KIND_LEVEL_HIGH = 4'd0;
    localparam logic [3:0] KIND_LEVEL_LOW  = 4'd1;
    localparam logic [3:0] KIND_RISE       = 4'd2;
    localparam logic [3:0] KIND_FALL       = 4'd3;
    localparam logic [3:0] KIND_UART       = 4'd4;
    localparam logic [3:0] KIND_TIMER      = 4'd5;
    localparam logic [3:0] KIND_VBLANK     = 4'd6;
    localparam logic [3:0] KIND_HBLANK     = 4'd7;
    localparam logic [3:0] KIND_ALWAYS     = 4'd8;
    localparam logic [3:0] KIND_NONE       = 4'd15;

    // Result kinds on the output channel.
    localparam logic [1:0] RES_FIRE = 2'd0;
    localparam logic [1:0] RES_DONE = 2'd1;
    localparam logic [1:0] RES_FULL = 2'd2;

    // Sequencer states.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TIME  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_POST  = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_DEL   = 7'b0100000,
        S_FINAL = 7'b1000000
    } state_t;

    // Operands presented to the shared 64-bit unit.
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ref_val;
    } alu_req_t;

    // Results returned by the shared 64-bit unit.
    typedef struct packed {
        logic [63:0] sum;
        logic        gt;
    } alu_rsp_t;

endpackage

// ===== design/pett_alu.sv =====
// Shared 64-bit adder and unsigned compare used by the sequencer.
`timescale 1ns / 1ps

module pett_alu
    import pett_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    // One wide add for count and deadline updates, one compare for expiry.
    always_comb
    begin
        rsp.sum = req.a + req.b;
        rsp.gt  = (req.a > req.ref_val);
    end

endmodule

// ===== design/polled_event_trigger_table_unit.sv =====
// Top level of the polled event trigger table.
`timescale 1ns / 1ps

// Usage: the input channel (in_valid / in_ready) takes one command word: poll, add a
// slot, delete by tag, enable or disable. The output channel (out_valid / out_ready)
// returns zero or more fire words, one per slot that hit, followed by one final word
// with last set that gives the outcome (done or table full).
// A word is taken one at a time. Each slot is visited by one sequencer step using
// a shared 64-bit add/compare unit, so the time from accept until in_ready returns
// can grow with SLOT_COUNT for an enabled poll, a delete and an add, while a disabled
// poll skips the walk; the per-slot walk through the table sets these times. Each
// result word appears on the output register in the cycle after it is produced.
// A single output register separates the channels: the next command is accepted
// while the final word still waits. When the receiver stalls, the sequencer holds
// at the pending fire word until the register frees up.
// Reset marks every slot inactive, disables triggers, clears the elapsed count and
// the previous samples; the first poll, add, enable or disable then starts the timebase.
module polled_event_trigger_table_unit
    import pett_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [31:0] gpio_sample,
    input  logic        uart_rx_ready,
    input  logic        vblank_now,
    input  logic        hblank_now,
    input  logic [31:0] timer_now,
    input  logic [3:0]  trigger_kind,
    input  logic [63:0] mask_or_period,
    input  logic [7:0]  handler_tag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [2:0]  slot_index,
    output logic [7:0]  fired_tag,
    output logic [31:0] argument,
    output logic        last
);

    localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

    // Sequencer and scalar state.
    state_t          state_reg, state_next;
    logic [IdxW-1:0] cnt_reg, cnt_next;
    logic [1:0]      final_kind_reg, final_kind_next;
    logic            enabled_reg, enabled_next;
    logic            started_reg, started_next;
    logic [63:0]     elapsed_reg, elapsed_next;
    logic [31:0]     prev_timer_reg, prev_timer_next;
    logic [31:0]     prev_gpio_reg, prev_gpio_next;
    logic [1:0]      prev_blank_reg, prev_blank_next;

    // Captured command word.
    logic [2:0]  op_reg;
    logic [31:0] gpio_reg;
    logic        uart_reg;
    logic [1:0]  blank_reg;
    logic [31:0] timer_reg;
    logic [3:0]  kind_reg;
    logic [63:0] mop_reg;
    logic [7:0]  tag_reg;

    // Slot table.
    logic [3:0]  slot_kind_reg [SLOT_COUNT];
    logic [63:0] slot_mop_reg  [SLOT_COUNT];
    logic [63:0] slot_dl_reg   [SLOT_COUNT];
    logic [7:0]  slot_tag_reg  [SLOT_COUNT];

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  res_kind_reg;
    logic [2:0]  res_slot_reg;
    logic [7:0]  res_tag_reg;
    logic [31:0] res_arg_reg;
    logic        res_last_reg;

    // Internal signals.
    logic            accept;
    alu_req_t        alu_req;
    alu_rsp_t        alu_rsp;
    logic [31:0]     delta;
    logic [3:0]      cur_kind;
    logic [31:0]     cur_mask;
    logic [31:0]     edge_bits;
    logic [1:0]      rise_blank;
    logic            hit;
    logic [31:0]     hit_arg;
    logic            emit;
    logic            emit_fire;
    logic            out_load;
    logic            slot_wr_en;
    logic            slot_clr_en;
    logic            dl_wr_en;
    logic [IdxW+2:0] cnt_wide;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign delta     = timer_reg - prev_timer_reg;
    assign cur_kind  = slot_kind_reg[cnt_reg];
    assign cur_mask  = slot_mop_reg[cnt_reg][31:0];
    assign edge_bits = gpio_reg ^ prev_gpio_reg;
    assign rise_blank = blank_reg & ~prev_blank_reg;
    assign cnt_wide  = {3'b000, cnt_reg};

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_req.a       = elapsed_reg;
        alu_req.b       = slot_mop_reg[cnt_reg];
        alu_req.ref_val = slot_dl_reg[cnt_reg];
        if (state_reg == S_TIME)
        begin
            alu_req.a = started_reg ? elapsed_reg : 64'd0;
            alu_req.b = {32'd0, (started_reg ? delta : timer_reg)};
        end
        else if (state_reg == S_ADD)
        begin
            alu_req.b = mop_reg;
        end
    end

    pett_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Hit test for the slot under the sequencer.
    always_comb
    begin
        hit     = 1'b0;
        hit_arg = 32'd0;
        unique case (cur_kind)
            KIND_LEVEL_HIGH:
            begin
                hit     = |(gpio_reg & cur_mask);
                hit_arg = gpio_reg;
            end
            KIND_LEVEL_LOW:
            begin
                hit     = |(~gpio_reg & cur_mask);
                hit_arg = gpio_reg;
            end
            KIND_RISE:
            begin
                hit     = |(edge_bits & gpio_reg & cur_mask);
                hit_arg = gpio_reg;
            end
            KIND_FALL:
            begin
                hit     = |(edge_bits & ~gpio_reg & cur_mask);
                hit_arg = gpio_reg;
            end
            KIND_UART:   hit = uart_reg;
            KIND_TIMER:  hit = alu_rsp.gt;
            KIND_VBLANK: hit = rise_blank[0];
            KIND_HBLANK: hit = rise_blank[1];
            KIND_ALWAYS: hit = 1'b1;
            default:     hit = 1'b0;
        endcase
    end

    // A fire word comes from the scan, a final word from the last state.
    assign emit_fire = (state_reg == S_SCAN) && hit;
    assign emit      = emit_fire || (state_reg == S_FINAL);
    assign out_load  = emit && (!out_valid_reg || out_ready);

    // Sequencer next state.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        final_kind_next = final_kind_reg;
        enabled_next    = enabled_reg;
        started_next    = started_reg;
        elapsed_next    = elapsed_reg;
        prev_timer_next = prev_timer_reg;
        prev_gpio_next  = prev_gpio_reg;
        prev_blank_next = prev_blank_reg;
        slot_wr_en      = 1'b0;
        slot_clr_en     = 1'b0;
        dl_wr_en        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    unique case (opcode)
                        OP_POLL, OP_ADD, OP_ENABLE, OP_DISABLE: state_next = S_TIME;
                        OP_DELETE: state_next = S_DEL;
                        default:
                        begin
                            final_kind_next = RES_DONE;
                            state_next      = S_FINAL;
                        end
                    endcase
                end
            end
            S_TIME:
            begin
                elapsed_next    = alu_rsp.sum;
                prev_timer_next = timer_reg;
                started_next    = 1'b1;
                if (!started_reg)
                begin
                    prev_gpio_next  = gpio_reg;
                    prev_blank_next = blank_reg;
                end
                state_next = enabled_reg ? S_SCAN : S_POST;
            end
            S_SCAN:
            begin
                if (!hit || out_load)
                begin
                    dl_wr_en = hit && (cur_kind == KIND_TIMER);
                    if (cnt_reg == LastIdx)
                    begin
                        prev_gpio_next  = gpio_reg;
                        prev_blank_next = blank_reg;
                        state_next      = S_POST;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_POST:
            begin
                cnt_next        = '0;
                final_kind_next = RES_DONE;
                state_next      = S_FINAL;
                if (op_reg == OP_ENABLE)
                begin
                    enabled_next = 1'b1;
                end
                else if (op_reg == OP_DISABLE)
                begin
                    enabled_next = 1'b0;
                end
                else if (op_reg == OP_ADD)
                begin
                    if (kind_reg > KIND_ALWAYS)
                    begin
                        final_kind_next = RES_FULL;
                    end
                    else
                    begin
                        state_next = S_ADD;
                    end
                end
            end
            S_ADD:
            begin
                if (cur_kind == KIND_NONE)
                begin
                    slot_wr_en      = 1'b1;
                    final_kind_next = RES_DONE;
                    state_next      = S_FINAL;
                end
                else if (cnt_reg == LastIdx)
                begin
                    final_kind_next = RES_FULL;
                    state_next      = S_FINAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DEL:
            begin
                slot_clr_en = (cur_kind != KIND_NONE) && (slot_tag_reg[cnt_reg] == tag_reg);
                if (cnt_reg == LastIdx)
                begin
                    final_kind_next = RES_DONE;
                    state_next      = S_FINAL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FINAL:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output valid follows loads and takes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            final_kind_reg <= RES_DONE;
            enabled_reg    <= 1'b0;
            started_reg    <= 1'b0;
            elapsed_reg    <= 64'd0;
            prev_timer_reg <= 32'd0;
            prev_gpio_reg  <= 32'd0;
            prev_blank_reg <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            final_kind_reg <= final_kind_next;
            enabled_reg    <= enabled_next;
            started_reg    <= started_next;
            elapsed_reg    <= elapsed_next;
            prev_timer_reg <= prev_timer_next;
            prev_gpio_reg  <= prev_gpio_next;
            prev_blank_reg <= prev_blank_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Slot kinds reset to inactive; everything else waits for a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_kind_reg[i] <= KIND_NONE;
            end
        end
        else if (slot_wr_en)
        begin
            slot_kind_reg[cnt_reg] <= kind_reg;
        end
        else if (slot_clr_en)
        begin
            slot_kind_reg[cnt_reg] <= KIND_NONE;
        end
    end

    // Slot payload and deadlines.
    always_ff @(posedge clk)
    begin
        if (slot_wr_en)
        begin
            slot_mop_reg[cnt_reg] <= mop_reg;
            slot_tag_reg[cnt_reg] <= tag_reg;
            slot_dl_reg[cnt_reg]  <= (kind_reg == KIND_TIMER) ? alu_rsp.sum : 64'd0;
        end
        else if (dl_wr_en)
        begin
            slot_dl_reg[cnt_reg] <= alu_rsp.sum;
        end
    end

    // Command capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode;
            gpio_reg  <= gpio_sample;
            uart_reg  <= uart_rx_ready;
            blank_reg <= {hblank_now, vblank_now};
            timer_reg <= timer_now;
            kind_reg  <= trigger_kind;
            mop_reg   <= mask_or_period;
            tag_reg   <= handler_tag;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (emit_fire)
            begin
                res_kind_reg <= RES_FIRE;
                res_slot_reg <= cnt_wide[2:0];
                res_tag_reg  <= slot_tag_reg[cnt_reg];
                res_arg_reg  <= hit_arg;
                res_last_reg <= 1'b0;
            end
            else
            begin
                res_kind_reg <= final_kind_reg;
                res_slot_reg <= 3'd0;
                res_tag_reg  <= 8'd0;
                res_arg_reg  <= 32'd0;
                res_last_reg <= 1'b1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = res_kind_reg;
    assign slot_index  = res_slot_reg;
    assign fired_tag   = res_tag_reg;
    assign argument    = res_arg_reg;
    assign last        = res_last_reg;

    // A final word always frees the input side on the next cycle.
    a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL && out_load) |=> in_ready)
        else $error("final word loaded but block not ready");

    // Only one command word is taken before its final word is produced.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second word accepted while busy");

    // Fire words never carry last; outcome words always do.
    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_kind_reg == RES_FIRE) |-> !res_last_reg)
        else $error("fire word marked last");

    a_outcome_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_kind_reg != RES_FIRE) |-> res_last_reg)
        else $error("outcome word not marked last");

    // Once the timebase has started it stays started.
    a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("timebase start flag dropped");

endmodule
